// ----- rtl/wlfd_pkg.sv -----
`default_nettype none

package wlfd_pkg;

    // field and register widths
    localparam int MODE_W     = 2;
    localparam int MINUTE_W   = 11;
    localparam int SECOND_W   = 6;
    localparam int WEEKDAY_W  = 3;
    localparam int LEN_W      = 8;
    localparam int DUTY_W     = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 11;

    // elapsed seconds: 2047 * 60 + 63 fits in 17 bits
    localparam int ELAPSED_W  = 17;
    // fade end: 255 * 60 = 15300, hold end: 510 * 60 = 30600
    localparam int FADE_END_W = 14;
    localparam int HOLD_END_W = 15;
    localparam int FADE_END_MAX = 15300;

    localparam int RAMP_VAL_W = 16;
    localparam int PROD_W     = DUTY_W + RAMP_VAL_W;

    localparam int RAMP_SIZE_DEFAULT = 256;

    typedef logic [DUTY_W-1:0]     duty_t;
    typedef logic [ELAPSED_W-1:0]  elapsed_t;
    typedef logic [FADE_END_W-1:0] fade_end_t;
    typedef logic [HOLD_END_W-1:0] hold_end_t;
    typedef logic [RAMP_VAL_W-1:0] ramp_val_t;
    typedef logic [PROD_W-1:0]     prod_t;

    localparam logic [MODE_W-1:0] MODE_FORCE_ON = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARMED    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd2;

    localparam duty_t DUTY_LIMIT = 10'd1000;

    localparam logic [WEEKDAY_W-1:0] DAY_SUNDAY   = 3'd0;
    localparam logic [WEEKDAY_W-1:0] DAY_SATURDAY = 3'd6;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RUN_MODE       = 3'd0,
        REG_ALARM_MINUTE   = 3'd1,
        REG_WEEKEND_ENABLE = 3'd2,
        REG_FADE_LENGTH    = 3'd3,
        REG_SNOOZE_LENGTH  = 3'd4,
        REG_DUTY_CEILING   = 3'd5,
        REG_LIGHTS_ON_DUTY = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [MODE_W-1:0]   run_mode;
        logic [MINUTE_W-1:0] alarm_minute;
        logic                weekend_enable;
        logic [LEN_W-1:0]    fade_length;
        logic [LEN_W-1:0]    snooze_length;
        duty_t               duty_ceiling;
        duty_t               lights_on_duty;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        run_mode:       MODE_ARMED,
        alarm_minute:   11'd405,
        weekend_enable: 1'b0,
        fade_length:    8'd30,
        snooze_length:  8'd30,
        duty_ceiling:   10'd950,
        lights_on_duty: 10'd600
    };

    // TIMED: armed and past the alarm minute, window not yet resolved
    typedef enum logic [1:0] {
        KIND_OFF   = 2'd0,
        KIND_FIXED = 2'd1,
        KIND_RAMP  = 2'd2,
        KIND_TIMED = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t kind;
        duty_t duty;
    } ctl_t;

    function automatic duty_t sat_duty(input duty_t d);
        return (d > DUTY_LIMIT) ? DUTY_LIMIT : d;
    endfunction

    // ---------------------------------------------------------------
    // Ramp curve, evaluated at elaboration only.
    // ---------------------------------------------------------------
    localparam logic [63:0] EXP_INT_Q24 [6] = '{
        64'd16777216, 64'd45605201, 64'd123967790,
        64'd336979391, 64'd916004956, 64'd2489959628
    };
    localparam logic [63:0] EIGHT_TENTHS_Q24 = 64'd13421773;
    localparam logic [63:0] ONE_Q48          = 64'd1 << 48;

    function automatic logic [63:0] div_u64(input logic [63:0] num,
                                            input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        int          i;
        q = '0;
        r = '0;
        for (i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(+-m), m in Q32, result in Q24
    function automatic logic [63:0] exp_q24(input logic [63:0] m, input logic neg);
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] ep;
        int          k;
        n    = m >> 32;
        f    = {32'd0, m[31:0]};
        term = 64'd1 << 32;
        sum  = term;
        if (n > 64'd5) n = 64'd5;
        for (k = 1; k <= 13; k++) begin
            term = (term * f) >> 32;
            term = div_u64(term, 64'(k));
            sum  = sum + term;
        end
        ep = ((sum >> 8) * EXP_INT_Q24[n[2:0]]) >> 24;
        if (ep == 64'd0) ep = 64'd1;
        return neg ? div_u64(ONE_Q48, ep) : ep;
    endfunction

    function automatic logic [63:0] sig_q24(input logic [63:0] m, input logic neg);
        return div_u64(ONE_Q48, EIGHT_TENTHS_Q24 + exp_q24(m, neg));
    endfunction

    function automatic ramp_val_t ramp_entry(input int idx, input int size);
        logic [63:0] gmin;
        logic [63:0] gmax;
        logic [63:0] den;
        logic [63:0] two_i;
        logic [63:0] sz;
        logic [63:0] mag;
        logic [63:0] g;
        logic [63:0] nv;
        logic        neg;
        gmin  = sig_q24(64'd5 << 32, 1'b0);
        gmax  = sig_q24(64'd5 << 32, 1'b1);
        den   = gmax - gmin;
        if (den == 64'd0) den = 64'd1;
        sz    = 64'(size);
        two_i = 64'(idx) << 1;
        if (two_i <= sz) begin
            mag = 64'd5 * (sz - two_i);
            neg = 1'b0;
        end else begin
            mag = 64'd5 * (two_i - sz);
            neg = 1'b1;
        end
        g = sig_q24(div_u64(mag << 32, sz), neg);
        if (g < gmin) g = gmin;
        nv = div_u64((g - gmin) * 64'd32768 + (den >> 1), den);
        if (nv > 64'd32768) nv = 64'd32768;
        return nv[RAMP_VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/wlfd_front.sv -----
`default_nettype none

// Three decode stages: mode/weekday/alarm test, elapsed seconds,
// window compare and divider numerator.
module wlfd_front #(
    parameter int RAMP_TABLE_SIZE = wlfd_pkg::RAMP_SIZE_DEFAULT
) (
    input  wire                                          aclk,
    input  wire                                          aresetn,
    input  wlfd_pkg::cfg_t                               cfg,
    input  wlfd_pkg::fade_end_t                          fade_end,
    input  wlfd_pkg::hold_end_t                          hold_end,
    input  wire                                          in_valid,
    output logic                                         in_ready,
    input  wire                                          in_time_valid,
    input  wire  [wlfd_pkg::MINUTE_W-1:0]                in_minute,
    input  wire  [wlfd_pkg::SECOND_W-1:0]                in_second,
    input  wire  [wlfd_pkg::WEEKDAY_W-1:0]               in_weekday,
    output logic                                         out_valid,
    input  wire                                          out_ready,
    output wlfd_pkg::ctl_t                               out_ctl,
    output logic [$clog2(wlfd_pkg::FADE_END_MAX * RAMP_TABLE_SIZE)-1:0] out_num
);

    localparam int NumW = $clog2(wlfd_pkg::FADE_END_MAX * RAMP_TABLE_SIZE);

    logic rdy1, rdy2, rdy3;

    logic                          v1_reg, v2_reg, v3_reg;
    wlfd_pkg::ctl_t                ctl1_reg, ctl2_reg, ctl3_reg;
    wlfd_pkg::ctl_t                ctl1_next, ctl3_next;
    logic                          keep1_next;
    logic [wlfd_pkg::MINUTE_W-1:0] diff1_reg;
    logic [wlfd_pkg::SECOND_W-1:0] sec1_reg;
    wlfd_pkg::elapsed_t            elapsed2_reg, elapsed2_next;
    logic [NumW-1:0]               num3_reg, num3_next;
    logic                          weekend;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: mode decode; ticks with no result never enter
    always_comb begin
        weekend    = (in_weekday == wlfd_pkg::DAY_SUNDAY) ||
                     (in_weekday == wlfd_pkg::DAY_SATURDAY);
        ctl1_next  = '{kind: wlfd_pkg::KIND_OFF, duty: '0};
        keep1_next = 1'b0;
        case (cfg.run_mode)
            wlfd_pkg::MODE_FORCE_ON: begin
                ctl1_next.kind = wlfd_pkg::KIND_FIXED;
                ctl1_next.duty = wlfd_pkg::sat_duty(cfg.lights_on_duty);
                keep1_next     = 1'b1;
            end
            wlfd_pkg::MODE_OFF: begin
                keep1_next = 1'b1;
            end
            wlfd_pkg::MODE_ARMED: begin
                keep1_next = in_time_valid;
                if (!(weekend && !cfg.weekend_enable) && (in_minute >= cfg.alarm_minute)) begin
                    ctl1_next.kind = wlfd_pkg::KIND_TIMED;
                end
            end
            default: begin
                keep1_next = 1'b0;
            end
        endcase
    end

    // stage 2: elapsed seconds since the alarm minute
    assign elapsed2_next = wlfd_pkg::elapsed_t'(wlfd_pkg::elapsed_t'(diff1_reg) * 17'd60)
                         + wlfd_pkg::elapsed_t'(sec1_reg);

    // stage 3: pick fade, hold or off
    always_comb begin
        ctl3_next = ctl2_reg;
        num3_next = '0;
        if (ctl2_reg.kind == wlfd_pkg::KIND_TIMED) begin
            ctl3_next.duty = wlfd_pkg::sat_duty(cfg.duty_ceiling);
            if (elapsed2_reg < wlfd_pkg::elapsed_t'(fade_end)) begin
                ctl3_next.kind = wlfd_pkg::KIND_RAMP;
                num3_next = NumW'(elapsed2_reg[wlfd_pkg::FADE_END_W-1:0])
                          * NumW'(RAMP_TABLE_SIZE);
            end else if (elapsed2_reg < wlfd_pkg::elapsed_t'(hold_end)) begin
                ctl3_next.kind = wlfd_pkg::KIND_FIXED;
            end else begin
                ctl3_next.kind = wlfd_pkg::KIND_OFF;
                ctl3_next.duty = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid && keep1_next;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            ctl1_reg  <= ctl1_next;
            diff1_reg <= in_minute - cfg.alarm_minute;
            sec1_reg  <= in_second;
        end
        if (rdy2) begin
            ctl2_reg     <= ctl1_reg;
            elapsed2_reg <= elapsed2_next;
        end
        if (rdy3) begin
            ctl3_reg <= ctl3_next;
            num3_reg <= num3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_ctl   = ctl3_reg;
    assign out_num   = num3_reg;

endmodule

`default_nettype wire

// ----- rtl/wlfd_div.sv -----
`default_nettype none

// Ramp index = num / fade_end, one quotient bit per stage, MSB first.
// The quotient is known to be below RAMP_TABLE_SIZE.
module wlfd_div #(
    parameter int RAMP_TABLE_SIZE = wlfd_pkg::RAMP_SIZE_DEFAULT
) (
    input  wire                                          aclk,
    input  wire                                          aresetn,
    input  wlfd_pkg::fade_end_t                          fade_end,
    input  wire                                          in_valid,
    output logic                                         in_ready,
    input  wlfd_pkg::ctl_t                               in_ctl,
    input  wire  [$clog2(wlfd_pkg::FADE_END_MAX * RAMP_TABLE_SIZE)-1:0] in_num,
    output logic                                         out_valid,
    input  wire                                          out_ready,
    output wlfd_pkg::ctl_t                               out_ctl,
    output logic [$clog2(RAMP_TABLE_SIZE)-1:0]           out_idx
);

    localparam int NumW = $clog2(wlfd_pkg::FADE_END_MAX * RAMP_TABLE_SIZE);
    localparam int QW   = $clog2(RAMP_TABLE_SIZE);

    logic                 rdy     [QW+1];
    logic                 vld_s   [QW+1];
    logic [NumW-1:0]      rem_s   [QW+1];
    logic [QW-1:0]        q_s     [QW+1];
    wlfd_pkg::ctl_t       ctl_s   [QW+1];

    logic                 vld_reg [QW];
    logic [NumW-1:0]      rem_reg [QW];
    logic [QW-1:0]        q_reg   [QW];
    wlfd_pkg::ctl_t       ctl_reg [QW];

    assign vld_s[0]  = in_valid;
    assign rem_s[0]  = in_num;
    assign q_s[0]    = '0;
    assign ctl_s[0]  = in_ctl;
    assign rdy[QW]   = out_ready;
    assign in_ready  = rdy[0];

    for (genvar i = 0; i < QW; i++) begin : g_step
        localparam int Bit = QW - 1 - i;

        logic [NumW-1:0] trial;
        logic            fits;
        logic [QW-1:0]   q_next;

        assign rdy[i]     = !vld_reg[i] || rdy[i+1];
        assign vld_s[i+1] = vld_reg[i];
        assign rem_s[i+1] = rem_reg[i];
        assign q_s[i+1]   = q_reg[i];
        assign ctl_s[i+1] = ctl_reg[i];

        always_comb begin
            trial       = NumW'(fade_end) << Bit;
            fits        = rem_s[i] >= trial;
            q_next      = q_s[i];
            q_next[Bit] = fits;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                vld_reg[i] <= vld_s[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                rem_reg[i] <= fits ? (rem_s[i] - trial) : rem_s[i];
                q_reg[i]   <= q_next;
                ctl_reg[i] <= ctl_s[i];
            end
        end
    end

    assign out_valid = vld_s[QW];
    assign out_ctl   = ctl_s[QW];
    assign out_idx   = q_s[QW];

endmodule

`default_nettype wire

// ----- rtl/wlfd_ramp.sv -----
`default_nettype none

// Curve lookup, scale by the ceiling duty, round, output register.
module wlfd_ramp #(
    parameter int RAMP_TABLE_SIZE = wlfd_pkg::RAMP_SIZE_DEFAULT
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wlfd_pkg::ctl_t                     in_ctl,
    input  wire  [$clog2(RAMP_TABLE_SIZE)-1:0] in_idx,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic                               m_drive_on,
    output logic [wlfd_pkg::DUTY_W-1:0]        m_duty_out
);

    localparam int QW = $clog2(RAMP_TABLE_SIZE);

    wlfd_pkg::ramp_val_t rom [RAMP_TABLE_SIZE];

    for (genvar g = 0; g < RAMP_TABLE_SIZE; g++) begin : g_rom
        localparam wlfd_pkg::ramp_val_t Entry = wlfd_pkg::ramp_entry(g, RAMP_TABLE_SIZE);
        assign rom[g] = Entry;
    end

    logic                rdy1, rdy2, rdy3;
    logic                v1_reg, v2_reg;
    wlfd_pkg::ctl_t      ctl1_reg, ctl2_reg;
    wlfd_pkg::ramp_val_t n1_reg;
    wlfd_pkg::prod_t     prod2_reg;
    wlfd_pkg::prod_t     rounded;
    logic                drive_next;
    wlfd_pkg::duty_t     duty_next;
    logic                m_valid_reg;
    logic                drive_reg;
    wlfd_pkg::duty_t     duty_reg;

    assign rdy3     = !m_valid_reg || m_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Q1.15 product, round half up
    always_comb begin
        rounded    = prod2_reg + wlfd_pkg::prod_t'(16384);
        drive_next = ctl2_reg.kind != wlfd_pkg::KIND_OFF;
        case (ctl2_reg.kind)
            wlfd_pkg::KIND_RAMP:  duty_next = rounded[15 +: wlfd_pkg::DUTY_W];
            wlfd_pkg::KIND_FIXED: duty_next = ctl2_reg.duty;
            default:              duty_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg      <= in_valid;
            if (rdy2) v2_reg      <= v1_reg;
            if (rdy3) m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            ctl1_reg <= in_ctl;
            n1_reg   <= rom[in_idx[QW-1:0]];
        end
        if (rdy2) begin
            ctl2_reg  <= ctl1_reg;
            prod2_reg <= wlfd_pkg::prod_t'(ctl1_reg.duty) * wlfd_pkg::prod_t'(n1_reg);
        end
        if (rdy3) begin
            drive_reg <= drive_next;
            duty_reg  <= duty_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_drive_on = drive_reg;
    assign m_duty_out = duty_reg;

endmodule

`default_nettype wire

// ----- rtl/wakeup_light_fade_duty.sv -----
`default_nettype none

// Port group  Dir  Handshake          Fields
// s_          in   s_valid / s_ready  s_time_valid, s_minute_of_day, s_second_now, s_weekday
// m_          out  m_valid / m_ready  m_drive_on, m_duty_out
// cfg_        in   cfg_wr_en          cfg_addr, cfg_wdata (write only)
//
// One word per cycle sustained while m_ready stays high. The pipeline stages are
// three decode stages, one stage per quotient bit of the ramp
// index divider, table read, scale multiply, output register.
// Sync reset clears the valids and loads register defaults; the table is constant.
// A full stage holds while the next one is full and stalled; bubbles close up, and a
// tick that yields no word is dropped at the first stage.
module wakeup_light_fade_duty #(
    parameter int RAMP_TABLE_SIZE = wlfd_pkg::RAMP_SIZE_DEFAULT
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 s_time_valid,
    input  wire  [wlfd_pkg::MINUTE_W-1:0]       s_minute_of_day,
    input  wire  [wlfd_pkg::SECOND_W-1:0]       s_second_now,
    input  wire  [wlfd_pkg::WEEKDAY_W-1:0]      s_weekday,

    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic                                m_drive_on,
    output logic [wlfd_pkg::DUTY_W-1:0]         m_duty_out,

    input  wire                                 cfg_wr_en,
    input  wire  [wlfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [wlfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int NumW = $clog2(wlfd_pkg::FADE_END_MAX * RAMP_TABLE_SIZE);
    localparam int QW   = $clog2(RAMP_TABLE_SIZE);

    wlfd_pkg::cfg_t      cfg_reg;
    wlfd_pkg::fade_end_t fade_end_reg, fade_end_next;
    wlfd_pkg::hold_end_t hold_end_reg, hold_end_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= wlfd_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            case (wlfd_pkg::reg_idx_t'(cfg_addr))
                wlfd_pkg::REG_RUN_MODE:
                    cfg_reg.run_mode       <= cfg_wdata[wlfd_pkg::MODE_W-1:0];
                wlfd_pkg::REG_ALARM_MINUTE:
                    cfg_reg.alarm_minute   <= cfg_wdata[wlfd_pkg::MINUTE_W-1:0];
                wlfd_pkg::REG_WEEKEND_ENABLE:
                    cfg_reg.weekend_enable <= cfg_wdata[0];
                wlfd_pkg::REG_FADE_LENGTH:
                    cfg_reg.fade_length    <= cfg_wdata[wlfd_pkg::LEN_W-1:0];
                wlfd_pkg::REG_SNOOZE_LENGTH:
                    cfg_reg.snooze_length  <= cfg_wdata[wlfd_pkg::LEN_W-1:0];
                wlfd_pkg::REG_DUTY_CEILING:
                    cfg_reg.duty_ceiling   <= cfg_wdata[wlfd_pkg::DUTY_W-1:0];
                wlfd_pkg::REG_LIGHTS_ON_DUTY:
                    cfg_reg.lights_on_duty <= cfg_wdata[wlfd_pkg::DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // window bounds in seconds, recomputed from the registers every cycle
    assign fade_end_next = wlfd_pkg::fade_end_t'(cfg_reg.fade_length) * 14'd60;
    assign hold_end_next = (wlfd_pkg::hold_end_t'(cfg_reg.fade_length)
                          + wlfd_pkg::hold_end_t'(cfg_reg.snooze_length)) * 15'd60;

    always_ff @(posedge aclk) begin
        fade_end_reg <= fade_end_next;
        hold_end_reg <= hold_end_next;
    end

    logic            fr_valid, fr_ready;
    wlfd_pkg::ctl_t  fr_ctl;
    logic [NumW-1:0] fr_num;
    logic            dv_valid, dv_ready;
    wlfd_pkg::ctl_t  dv_ctl;
    logic [QW-1:0]   dv_idx;

    wlfd_front #(
        .RAMP_TABLE_SIZE (RAMP_TABLE_SIZE)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .fade_end      (fade_end_reg),
        .hold_end      (hold_end_reg),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_time_valid (s_time_valid),
        .in_minute     (s_minute_of_day),
        .in_second     (s_second_now),
        .in_weekday    (s_weekday),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_ctl       (fr_ctl),
        .out_num       (fr_num)
    );

    wlfd_div #(
        .RAMP_TABLE_SIZE (RAMP_TABLE_SIZE)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fade_end  (fade_end_reg),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_ctl    (fr_ctl),
        .in_num    (fr_num),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_ctl   (dv_ctl),
        .out_idx   (dv_idx)
    );

    wlfd_ramp #(
        .RAMP_TABLE_SIZE (RAMP_TABLE_SIZE)
    ) u_ramp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (dv_valid),
        .in_ready   (dv_ready),
        .in_ctl     (dv_ctl),
        .in_idx     (dv_idx),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive_on (m_drive_on),
        .m_duty_out (m_duty_out)
    );

endmodule

`default_nettype wire

// ----- rtl/wlfd_checker.sv -----
`default_nettype none

module wlfd_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire                          m_drive_on,
    input wire [wlfd_pkg::DUTY_W-1:0]   m_duty_out
);

    // a word waiting at the output does not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_on) && $stable(m_duty_out))
        else $error("output word changed while stalled");

    // off means zero duty
    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_drive_on |-> m_duty_out == '0)
        else $error("nonzero duty with drive off");

    // duty never above full scale
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_duty_out <= wlfd_pkg::DUTY_LIMIT)
        else $error("duty above limit");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind wakeup_light_fade_duty wlfd_checker u_checker (.*);

`default_nettype wire
